FILE: sv/sfh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfh_pkg: shared types and constants for the smoothed follower heading block
// Holds the fixed field widths, the sequencer states, the control group that
// drives the CORDIC unit and the arctangent table of that unit.
// ----------------------------------------------------------------------------
package sfh_pkg;

	// Field widths fixed by the interface.
	localparam int COORD_W   = 24;
	localparam int HEADING_W = 16;
	localparam int RATE_W    = 17;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// Internal datapath widths.
	localparam int STEP_W    = COORD_W + 1;
	localparam int PROD_W    = STEP_W + RATE_W + 1;
	localparam int CORDIC_W  = 48;
	localparam int CORDIC_SH = 20;
	localparam int ANGLE_W   = 32;
	localparam int TABLE_LEN = 24;
	localparam int IT_W      = 5;

	// Defaults for the top-level parameters.
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ANGLE_BITS_DEF   = 16;

	// Rate of 1.0 in Q1.16 and the reset weight of 0.3.
	localparam logic [RATE_W-1:0] RATE_ONE   = 17'd65536;
	localparam logic [RATE_W-1:0] RATE_RESET = 17'd19661;

	// Angles in units of one turn over 2^32.
	localparam logic [ANGLE_W-1:0] OFFSET_2PI_3 = 32'h5555_5555;
	localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

	// Register index of the smoothing weight.
	localparam logic [APB_AW-3:0] REG_RATE = 1'b0;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MULX,
		S_MULY,
		S_PREP,
		S_ROT,
		S_FIN
	} sfh_state_t;

	// Commands from the sequencer to the CORDIC unit.
	typedef struct packed {
		logic start;
		logic step;
	} sfh_cord_ctl_t;

	// arctan(2^-i) in units of one turn over 2^32.
	function automatic logic [ANGLE_W-1:0] sfh_arc(input logic [IT_W-1:0] i);
		logic [ANGLE_W-1:0] a;
		case (i)
			5'd0:    a = 32'h2000_0000;
			5'd1:    a = 32'h12E4_051E;
			5'd2:    a = 32'h09FB_385B;
			5'd3:    a = 32'h0511_11D4;
			5'd4:    a = 32'h028B_0D43;
			5'd5:    a = 32'h0145_D7E1;
			5'd6:    a = 32'h00A2_F61E;
			5'd7:    a = 32'h0051_7C55;
			5'd8:    a = 32'h0028_BE53;
			5'd9:    a = 32'h0014_5F2F;
			5'd10:   a = 32'h000A_2F98;
			5'd11:   a = 32'h0005_17CC;
			5'd12:   a = 32'h0002_8BE6;
			5'd13:   a = 32'h0001_45F3;
			5'd14:   a = 32'h0000_A2FA;
			5'd15:   a = 32'h0000_517D;
			5'd16:   a = 32'h0000_28BE;
			5'd17:   a = 32'h0000_145F;
			5'd18:   a = 32'h0000_0A30;
			5'd19:   a = 32'h0000_0518;
			5'd20:   a = 32'h0000_028C;
			5'd21:   a = 32'h0000_0146;
			5'd22:   a = 32'h0000_00A3;
			5'd23:   a = 32'h0000_0051;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

FILE: sv/sfh_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfh_cordic: iterative vectoring CORDIC
// One shift-add-compare stage reused once per cycle. A start command loads
// the step vector (turned by a half turn in the left half plane); each step
// command performs one micro-rotation and accumulates its arctangent.
// ----------------------------------------------------------------------------
module sfh_cordic #(
	parameter int CORDIC_STEPS = sfh_pkg::CORDIC_STEPS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  sfh_pkg::sfh_cord_ctl_t               ctl,
	input  logic signed [sfh_pkg::STEP_W-1:0]    dx,
	input  logic signed [sfh_pkg::STEP_W-1:0]    dy,
	output logic [sfh_pkg::ANGLE_W-1:0]          angle,
	output logic                                 last
);
	import sfh_pkg::*;

	localparam int N_IT = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
	localparam logic [IT_W-1:0] LAST_IT = IT_W'(N_IT - 1);

	logic signed [CORDIC_W-1:0] x_q, y_q;
	logic [ANGLE_W-1:0]         z_q;
	logic [IT_W-1:0]            it_q;

	logic signed [CORDIC_W-1:0] x_ld, y_ld, xs, ys;

	// Scale the step vector up so the shifted terms keep their precision.
	assign x_ld = CORDIC_W'(dx) <<< CORDIC_SH;
	assign y_ld = CORDIC_W'(dy) <<< CORDIC_SH;

	// The shared barrel shifter.
	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;

	// Loop counter: iteration index and end of the rotation sweep.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			it_q <= '0;
		end else if (ctl.start) begin
			it_q <= '0;
		end else if (ctl.step) begin
			it_q <= it_q + 1'b1;
		end
	end

	// Rotation datapath.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			if (dx < 0) begin
				x_q <= -x_ld;
				y_q <= -y_ld;
				z_q <= HALF_TURN;
			end else begin
				x_q <= x_ld;
				y_q <= y_ld;
				z_q <= '0;
			end
		end else if (ctl.step) begin
			if (!y_q[CORDIC_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + sfh_arc(it_q);
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - sfh_arc(it_q);
			end
		end
	end

	assign angle = z_q;
	assign last  = (it_q == LAST_IT);

endmodule
`default_nettype wire

FILE: sv/smoothed_follower_heading.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smoothed_follower_heading: exponential follower with CORDIC step heading
// Moves a stored position toward each target beat and reports the new
// position together with the heading of the step plus a third of a turn.
// ----------------------------------------------------------------------------
// A beat is accepted in S_IDLE and runs through S_MULX, S_MULY, S_PREP,
// S_ROT (one micro-rotation per CORDIC step, capped at 24 steps) and S_FIN
// before the next acceptance; S_PREP skips to S_FIN when the position does
// not move. The single 18x25 multiplier is used once per axis; the CORDIC
// stage does one micro-rotation per cycle. target_stall is high while an item is in
// work. The result sits in an output register, so a new target is accepted
// while the previous result still waits; a result that cannot leave holds
// the sequencer in its final state. The smoothing weight catch_up_rate is
// register 0 at byte address 0, unsigned Q1.16, saturating at 1.0.
// ----------------------------------------------------------------------------
module smoothed_follower_heading #(
	parameter int CORDIC_STEPS = sfh_pkg::CORDIC_STEPS_DEF,
	parameter int ANGLE_BITS   = sfh_pkg::ANGLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [sfh_pkg::APB_AW-1:0]            paddr,
	input  logic [sfh_pkg::APB_DW-1:0]            pwdata,
	output logic [sfh_pkg::APB_DW-1:0]            prdata,
	output logic                                  pready,
	// Target channel
	input  logic                                  target_valid,
	output logic                                  target_stall,
	input  logic signed [sfh_pkg::COORD_W-1:0]    target_x,
	input  logic signed [sfh_pkg::COORD_W-1:0]    target_y,
	// Result channel
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic signed [sfh_pkg::COORD_W-1:0]    position_x,
	output logic signed [sfh_pkg::COORD_W-1:0]    position_y,
	output logic [sfh_pkg::HEADING_W-1:0]         heading
);
	import sfh_pkg::*;

	localparam int SHIFT = ANGLE_W - ANGLE_BITS;

	sfh_state_t state_q, state_d;

	logic [RATE_W-1:0]          rate_q, rate_sat;
	logic signed [COORD_W-1:0]  tx_q, ty_q, cur_x_q, cur_y_q;
	logic signed [PROD_W-1:0]   prod_q, prod_d, prod_rnd;
	logic signed [STEP_W-1:0]   diff, dx_q, dy_q, step_now;
	logic                       zero_q, zero_now;
	logic                       out_load;
	logic                       result_valid_q;
	logic signed [COORD_W-1:0]  position_x_q, position_y_q;
	logic [HEADING_W-1:0]       heading_q;
	logic signed [STEP_W-1:0]   nx, ny;
	logic [ANGLE_W-1:0]         z_used, z_full;
	logic [ANGLE_W:0]           z_rnd;
	logic [ANGLE_W-1:0]         h_wide;
	sfh_cord_ctl_t              cord_ctl;
	logic [ANGLE_W-1:0]         cord_angle;
	logic                       cord_last;
	logic                       cfg_wr;

	// Configuration register: the smoothing weight.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_RATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= RATE_RESET;
		end else if (cfg_wr) begin
			rate_q <= pwdata[RATE_W-1:0];
		end
	end

	assign prdata = (paddr[APB_AW-1:2] == REG_RATE) ? APB_DW'(rate_q) : '0;

	// Weights above 1.0 act as 1.0.
	assign rate_sat = (rate_q > RATE_ONE) ? RATE_ONE : rate_q;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and control.
	always_comb begin
		state_d        = state_q;
		target_stall   = 1'b1;
		cord_ctl.start = 1'b0;
		cord_ctl.step  = 1'b0;
		out_load       = 1'b0;
		case (state_q)
			S_IDLE: begin
				target_stall = 1'b0;
				if (target_valid) begin
					state_d = S_MULX;
				end
			end
			S_MULX: begin
				state_d = S_MULY;
			end
			S_MULY: begin
				state_d = S_PREP;
			end
			S_PREP: begin
				cord_ctl.start = 1'b1;
				state_d = zero_now ? S_FIN : S_ROT;
			end
			S_ROT: begin
				cord_ctl.step = 1'b1;
				if (cord_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Shared multiplier: r * (target - old) for x, then for y.
	assign diff = (state_q == S_MULY)
		? (STEP_W'(ty_q) - STEP_W'(cur_y_q))
		: (STEP_W'(tx_q) - STEP_W'(cur_x_q));
	assign prod_d = $signed({1'b0, rate_sat}) * diff;

	// The step is the product, in Q.16, rounded half up to whole units (Q25.0).
	assign prod_rnd = prod_q + PROD_W'(32768);
	assign step_now = prod_rnd[STEP_W+15:16];
	assign zero_now = (dx_q == '0) && (step_now == '0);

	// Item registers: captured target, product and step vector.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && target_valid) begin
			tx_q <= target_x;
			ty_q <= target_y;
		end
		if (state_q == S_MULX || state_q == S_MULY) begin
			prod_q <= prod_d;
		end
		if (state_q == S_MULY) begin
			dx_q <= step_now;
		end
		if (state_q == S_PREP) begin
			dy_q   <= step_now;
			zero_q <= zero_now;
		end
	end

	sfh_cordic #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (cord_ctl),
		.dx    (dx_q),
		.dy    (step_now),
		.angle (cord_angle),
		.last  (cord_last)
	);

	// New position and heading, rounded half up to ANGLE_BITS.
	assign nx     = STEP_W'(cur_x_q) + dx_q;
	assign ny     = STEP_W'(cur_y_q) + dy_q;
	assign z_used = zero_q ? '0 : cord_angle;
	assign z_full = z_used + OFFSET_2PI_3;
	assign z_rnd  = {1'b0, z_full} + ((ANGLE_W + 1)'(1) << (SHIFT - 1));
	assign h_wide = ANGLE_W'(z_rnd[ANGLE_W-1:SHIFT]);

	// Follower position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else if (out_load) begin
			cur_x_q <= nx[COORD_W-1:0];
			cur_y_q <= ny[COORD_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			position_x_q <= nx[COORD_W-1:0];
			position_y_q <= ny[COORD_W-1:0];
			heading_q    <= h_wide[HEADING_W-1:0];
		end
	end

	assign result_valid = result_valid_q;
	assign position_x   = position_x_q;
	assign position_y   = position_y_q;
	assign heading      = heading_q;

	// An accepted beat always starts the multiply phase.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		target_valid && !target_stall |=> state_q == S_MULX)
		else $error("accepted target did not start the multiply phase");

	// The stored position follows the delivered result.
	a_pos_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> cur_x_q == position_x && cur_y_q == position_y && result_valid)
		else $error("stored position differs from the result just loaded");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !result_valid_q || !result_stall)
		else $error("result register loaded while its beat was stalled");

	// The rotation phase ends only through the final state.
	a_rot_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ROT && cord_last |=> state_q == S_FIN)
		else $error("rotation sweep did not end in the final state");

endmodule
`default_nettype wire

FILE: verif/tb_smoothed_follower_heading.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_smoothed_follower_heading: self-checking bench for the follower block
// Sends target beats through the valid/stall channel and programs the catch-up
// rate over APB. Its own model of the exponential step and the CORDIC heading
// predicts each result beat, and every result is compared field by field.
// Random gaps are used on the target channel and random stalls on the result channel.
// ----------------------------------------------------------------------------
module tb_smoothed_follower_heading;
	import sfh_pkg::*;

	localparam int CORDIC_ITERS = (CORDIC_STEPS_DEF < TABLE_LEN) ? CORDIC_STEPS_DEF : TABLE_LEN;
	localparam int ANGLE_SHIFT  = ANGLE_W - ANGLE_BITS_DEF;
	localparam int SETTLE_CYCLES = 40;

	localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	// Register map: the rate at byte address 0, nothing at byte address 4.
	localparam logic [APB_AW-1:0] RATE_ADDR  = {REG_RATE, 2'b00};
	localparam logic [APB_AW-1:0] SPARE_ADDR = {1'b1, 2'b00};

	typedef struct {
		logic signed [COORD_W-1:0] pos_x;
		logic signed [COORD_W-1:0] pos_y;
		logic [HEADING_W-1:0]      heading;
	} step_result_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata, prdata;
	logic target_valid, target_stall;
	logic signed [COORD_W-1:0] target_x, target_y;
	logic result_valid, result_stall;
	logic signed [COORD_W-1:0] position_x, position_y;
	logic [HEADING_W-1:0] heading;

	// Arctangent of 2^-i in units of one turn over 2^32.
	logic [ANGLE_W-1:0] arc_turn [0:TABLE_LEN-1] = '{
		32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
		32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
		32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
		32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
		32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
		32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
	};

	// Shadow of the block state and its rate register.
	logic [RATE_W-1:0]         rate_q116 = RATE_RESET;
	logic signed [COORD_W-1:0] follow_x = '0;
	logic signed [COORD_W-1:0] follow_y = '0;

	step_result_t pending_steps [$];
	step_result_t want;
	int mismatches = 0;
	int stall_left = 0;
	bit idle_on = 1'b1;

	smoothed_follower_heading #(
		.CORDIC_STEPS(CORDIC_STEPS_DEF),
		.ANGLE_BITS(ANGLE_BITS_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.target_valid(target_valid),
		.target_stall(target_stall),
		.target_x(target_x),
		.target_y(target_y),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.position_x(position_x),
		.position_y(position_y),
		.heading(heading)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Weighted blend of target and old position, rounded half up.
	function automatic logic signed [COORD_W-1:0] blend(input longint aim, input longint prev,
			input longint w);
		longint acc;
		acc = w * aim + (longint'(65536) - w) * prev + 32768;
		return COORD_W'(acc >>> 16);
	endfunction

	// Vectoring CORDIC on the step, angle in turns over 2^32.
	function automatic logic [ANGLE_W-1:0] step_angle(input longint dx, input longint dy);
		longint vx, vy, sx, sy;
		logic [ANGLE_W-1:0] acc;
		int i;
		acc = '0;
		if (dx == 0 && dy == 0)
			return '0;
		vx = dx * (longint'(1) << CORDIC_SH);
		vy = dy * (longint'(1) << CORDIC_SH);
		// A vector in the left half plane is turned by half a turn first.
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			acc = HALF_TURN;
		end
		for (i = 0; i < CORDIC_ITERS; i++) begin
			sx = vx >>> i;
			sy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + sy;
				vy = vy - sx;
				acc = acc + arc_turn[i];
			end else begin
				vx = vx - sy;
				vy = vy + sx;
				acc = acc - arc_turn[i];
			end
		end
		return acc;
	endfunction

	// Advance the shadow position by one target beat and form its result.
	function automatic step_result_t predict_step(input logic signed [COORD_W-1:0] tx,
			input logic signed [COORD_W-1:0] ty);
		step_result_t res;
		longint w;
		logic [ANGLE_W-1:0] tilt;
		logic [ANGLE_W:0] rounded;
		w = (rate_q116 > RATE_ONE) ? longint'(RATE_ONE) : longint'(rate_q116);
		res.pos_x = blend(longint'(tx), longint'(follow_x), w);
		res.pos_y = blend(longint'(ty), longint'(follow_y), w);
		tilt = step_angle(longint'(res.pos_x) - longint'(follow_x),
			longint'(res.pos_y) - longint'(follow_y)) + OFFSET_2PI_3;
		rounded = {1'b0, tilt} + ((ANGLE_W + 1)'(1) << (ANGLE_SHIFT - 1));
		res.heading = rounded[ANGLE_W-1 -: HEADING_W];
		follow_x = res.pos_x;
		follow_y = res.pos_y;
		return res;
	endfunction

	// One APB write: a setup phase, an access phase, then psel is released.
	task automatic write_reg(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == RATE_ADDR)
			rate_q116 = data[RATE_W-1:0];
		@(posedge clk);
	endtask

	// Offer one target beat, optionally after a short gap, and predict it once taken.
	task automatic send_target(input logic signed [COORD_W-1:0] tx,
			input logic signed [COORD_W-1:0] ty);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			target_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		target_valid <= 1'b1;
		target_x <= tx;
		target_y <= ty;
		@(posedge clk);
		while (target_stall) @(posedge clk);
		pending_steps.push_back(predict_step(tx, ty));
	endtask

	// Hold off the sender until every result is back and the block is idle.
	task automatic wait_drain();
		target_valid <= 1'b0;
		@(posedge clk);
		while (pending_steps.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic signed [COORD_W-1:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return '0;
			3: return COORD_W'(-1);
			default: return COORD_W'(1);
		endcase
	endfunction

	function automatic logic [APB_DW-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return APB_DW'(RATE_ONE);
			1: return '0;
			2: return APB_DW'($urandom_range(65537, 131071));
			3: return APB_DW'(RATE_RESET);
			4: return APB_DW'($urandom_range(1, 64));
			default: return APB_DW'($urandom_range(1, 65535));
		endcase
	endfunction

	// Random targets: free points, some close to the follower, some repeated so
	// the follower settles, some at the extremes, some on one axis only.
	task automatic send_random_target(inout logic signed [COORD_W-1:0] last_x,
			inout logic signed [COORD_W-1:0] last_y);
		logic signed [COORD_W-1:0] tx, ty;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			tx = COORD_W'($urandom());
			ty = COORD_W'($urandom());
		end else if (pick < 65) begin
			tx = COORD_W'(follow_x + (int'($urandom_range(0, 2048)) - 1024));
			ty = COORD_W'(follow_y + (int'($urandom_range(0, 2048)) - 1024));
		end else if (pick < 75) begin
			tx = last_x;
			ty = last_y;
		end else if (pick < 85) begin
			tx = pick_extreme();
			ty = pick_extreme();
		end else if (pick < 93) begin
			tx = follow_x;
			ty = COORD_W'($urandom());
		end else begin
			tx = COORD_W'($urandom());
			ty = follow_y;
		end
		send_target(tx, ty);
		last_x = tx;
		last_y = ty;
	endtask

	// Reset weight, from rest: zero motion first, then the corners.
	task automatic test_reset_weight();
		send_target('0, '0);
		send_target(COORD_MAX, COORD_MAX);
		send_target(COORD_MIN, COORD_MIN);
		send_target(COORD_MAX, COORD_MIN);
		wait_drain();
	endtask

	// Full weight jumps straight to the target; steps cover zero motion, several quadrants and both axes.
	task automatic test_full_weight();
		write_reg(RATE_ADDR, APB_DW'(RATE_ONE));
		send_target(COORD_MIN, COORD_MIN);
		send_target(COORD_MAX, COORD_MAX);
		send_target(COORD_MAX, COORD_MAX);
		send_target(COORD_MIN, COORD_MAX);
		send_target('0, COORD_MIN);
		send_target('0, COORD_MAX);
		send_target(COORD_W'(-256), COORD_W'(100));
		send_target(COORD_W'(-255), COORD_W'(100));
		wait_drain();
	endtask

	// Rates above one saturate; upper data bits beyond the register are dropped.
	task automatic test_rate_above_one();
		write_reg(RATE_ADDR, 32'h0001_FFFF);
		send_target(COORD_W'(12345), COORD_W'(-999));
		send_target(COORD_W'(-1), COORD_W'(1));
		wait_drain();
		write_reg(RATE_ADDR, 32'hFFFF_0001);
		send_target(COORD_MAX, COORD_W'(-77));
		send_target(COORD_W'(5), COORD_MIN);
		wait_drain();
	endtask

	// Zero weight never moves the follower, so every heading is the offset.
	task automatic test_zero_weight();
		write_reg(RATE_ADDR, '0);
		send_target(COORD_MAX, COORD_MIN);
		send_target(COORD_MIN, COORD_MAX);
		wait_drain();
	endtask

	// The smallest nonzero weight, then a write to an unmapped address that must not stick.
	task automatic test_unmapped_write();
		write_reg(RATE_ADDR, APB_DW'(1));
		write_reg(SPARE_ADDR, APB_DW'(RATE_ONE));
		send_target(COORD_MAX, COORD_MAX);
		send_target(COORD_MIN, COORD_W'(-1));
		wait_drain();
	endtask

	// Random phases, each with its own rate and with idling turned on and off.
	task automatic test_random_phases();
		logic signed [COORD_W-1:0] last_x, last_y;
		int phase, n;
		last_x = '0;
		last_y = '0;
		for (phase = 0; phase < 6; phase++) begin
			write_reg(RATE_ADDR, pick_weight());
			for (n = 0; n < 300; n++) begin
				if (n % 50 == 0)
					idle_on = ($urandom_range(0, 3) != 0);
				send_random_target(last_x, last_y);
			end
			wait_drain();
		end
	endtask

	// Back-to-back beats with no gaps and no stalls.
	task automatic test_unthrottled_tail();
		logic signed [COORD_W-1:0] last_x, last_y;
		int n;
		last_x = follow_x;
		last_y = follow_y;
		idle_on = 1'b0;
		write_reg(RATE_ADDR, APB_DW'($urandom_range(1, 65535)));
		for (n = 0; n < 100; n++)
			send_random_target(last_x, last_y);
		wait_drain();
	endtask

	// Random result stalls in bursts, drawn only while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			result_stall <= 1'b0;
		end
	end

	// Compare every accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (pending_steps.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result: expected none, got x=%0d y=%0d heading=%0d",
					$time, position_x, position_y, heading);
			end else begin
				want = pending_steps.pop_front();
				if (position_x !== want.pos_x) begin
					mismatches++;
					$display("%0t position_x: expected %0d, got %0d",
						$time, want.pos_x, position_x);
				end
				if (position_y !== want.pos_y) begin
					mismatches++;
					$display("%0t position_y: expected %0d, got %0d",
						$time, want.pos_y, position_y);
				end
				if (heading !== want.heading) begin
					mismatches++;
					$display("%0t heading: expected %0d, got %0d",
						$time, want.heading, heading);
				end
			end
		end
	end

	// Guard against a hung run.
	initial begin
		#5_000_000;
		$display("tb_smoothed_follower_heading: errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		target_valid <= 1'b0;
		target_x <= '0;
		target_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_weight();
		test_full_weight();
		test_rate_above_one();
		test_zero_weight();
		test_unmapped_write();
		test_random_phases();
		test_unthrottled_tail();

		if (mismatches == 0 && pending_steps.size() == 0) begin
			$display("tb_smoothed_follower_heading: clean");
		end else begin
			$display("tb_smoothed_follower_heading: errors");
		end
		$finish;
	end

endmodule

FILE: sim.f
sv/sfh_pkg.sv
sv/sfh_cordic.sv
sv/smoothed_follower_heading.sv
verif/tb_smoothed_follower_heading.sv
